/* rtl/core/prd_pkg.sv */
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, types, register indexes and helper functions for the
// pinhole ray direction pipeline.
// ----------------------------------------------------------------------------
package prd_pkg;

	// Field widths.
	localparam int COORD_BITS = 12;
	localparam int DIR_BITS   = 16;
	localparam int FOCAL_W    = 32;
	localparam int ROW_W      = 48;
	localparam int CFG_W      = 48;
	localparam int IDX_W      = 3;

	// Fixed point layout.
	localparam int FRAC_BITS  = 16;
	localparam int DIFF_W     = FOCAL_W + 1;
	localparam int PROD_W     = 2 * FOCAL_W;
	localparam int NORM_BITS  = 30;
	localparam int VEC_W      = NORM_BITS + 1;
	localparam int MAT_W      = 16;
	localparam int MP_W       = MAT_W + VEC_W;
	localparam int W_W        = MP_W + 2;
	localparam int SQ_W       = 2 * NORM_BITS + 2;
	localparam int RT_W       = SQ_W / 2;
	localparam int RM_W       = RT_W + 1;
	localparam int LZ_W       = 7;

	localparam logic [DIR_BITS-1:0] MAX_POS = {1'b0, {(DIR_BITS-1){1'b1}}};

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_FOCAL_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_ROW0 = 3'd4;
	localparam logic [IDX_W-1:0] REG_INV_ROW1 = 3'd5;
	localparam logic [IDX_W-1:0] REG_INV_ROW2 = 3'd6;

	// Reset values: unit focal lengths, centers at zero, identity matrix.
	localparam logic [FOCAL_W-1:0] FOCAL_RST = 32'h0001_0000;
	localparam logic [ROW_W-1:0]   ROW0_RST  = 48'h4000_0000_0000;
	localparam logic [ROW_W-1:0]   ROW1_RST  = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0]   ROW2_RST  = 48'h0000_0000_4000;

	// Control that travels with every request.
	typedef struct packed {
		logic valid;
		logic zero;
	} prd_ctl_t;

	// Three-component vector held as sign and magnitude.
	typedef struct packed {
		logic [2:0] neg;
		logic [2:0][NORM_BITS-1:0] mag;
	} prd_vec_t;

	typedef logic [2:0][2:0][MAT_W-1:0] prd_mat_t;

	// Leading zero count over a 64-bit word; returns 64 for zero.
	function automatic logic [LZ_W-1:0] lzc64(input logic [63:0] x);
		logic [LZ_W-1:0] lz;
		lz = LZ_W'(64);
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				lz = LZ_W'(63 - i);
			end
		end
		return lz;
	endfunction

	// Shift left by the shared leading zero count and keep the top bits.
	function automatic logic [NORM_BITS-1:0] norm64(input logic [63:0] x,
			input logic [LZ_W-1:0] lz);
		logic [63:0] t;
		t = x << lz;
		return t[63 -: NORM_BITS];
	endfunction

endpackage

/* rtl/core/pinhole_ray_direction.sv */
// ----------------------------------------------------------------------------
// pinhole_ray_direction
// Throughput: one pixel per cycle; busy is always low.
// The depth is set by the 31-stage square root and 16-stage divider.
// Reset clears all valid bits and loads unit focal lengths, zero centers and
// the identity matrix. The receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
module pinhole_ray_direction (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [prd_pkg::COORD_BITS-1:0]      pixel_row,
	input  logic [prd_pkg::COORD_BITS-1:0]      pixel_col,
	input  logic                                cfg_we,
	input  logic [prd_pkg::IDX_W-1:0]           cfg_index,
	input  logic [prd_pkg::CFG_W-1:0]           cfg_data,
	output logic                                done,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_x,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_y,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_z
);

	logic [prd_pkg::FOCAL_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [2:0][prd_pkg::ROW_W-1:0] inv_row_q;
	prd_pkg::prd_mat_t mat;
	prd_pkg::prd_ctl_t cam_ctl, rot_ctl, sq_ctl;
	prd_pkg::prd_vec_t cam_vec, rot_vec, sq_vec;
	logic [prd_pkg::SQ_W-1:0] sumsq;
	logic [prd_pkg::RT_W-1:0] root;

	// The pipeline never holds off a request.
	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= prd_pkg::FOCAL_RST;
			focal_y_q    <= prd_pkg::FOCAL_RST;
			center_x_q   <= '0;
			center_y_q   <= '0;
			inv_row_q[0] <= prd_pkg::ROW0_RST;
			inv_row_q[1] <= prd_pkg::ROW1_RST;
			inv_row_q[2] <= prd_pkg::ROW2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				prd_pkg::REG_FOCAL_X: begin
					focal_x_q <= cfg_data[prd_pkg::FOCAL_W-1:0];
				end
				prd_pkg::REG_FOCAL_Y: begin
					focal_y_q <= cfg_data[prd_pkg::FOCAL_W-1:0];
				end
				prd_pkg::REG_CENTER_X: begin
					center_x_q <= cfg_data[prd_pkg::FOCAL_W-1:0];
				end
				prd_pkg::REG_CENTER_Y: begin
					center_y_q <= cfg_data[prd_pkg::FOCAL_W-1:0];
				end
				prd_pkg::REG_INV_ROW0: begin
					inv_row_q[0] <= cfg_data[prd_pkg::ROW_W-1:0];
				end
				prd_pkg::REG_INV_ROW1: begin
					inv_row_q[1] <= cfg_data[prd_pkg::ROW_W-1:0];
				end
				prd_pkg::REG_INV_ROW2: begin
					inv_row_q[2] <= cfg_data[prd_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Unpack the matrix: column 0 sits in the top bits of each row.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mat[i][j] = inv_row_q[i][prd_pkg::ROW_W-1-prd_pkg::MAT_W*j -: prd_pkg::MAT_W];
			end
		end
	end

	prd_cam u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.focal_x   (focal_x_q),
		.focal_y   (focal_y_q),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.ctl_out   (cam_ctl),
		.vec_out   (cam_vec)
	);

	prd_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (cam_ctl),
		.vec_in  (cam_vec),
		.mat     (mat),
		.ctl_out (rot_ctl),
		.vec_out (rot_vec),
		.sumsq   (sumsq)
	);

	prd_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (rot_ctl),
		.vec_in  (rot_vec),
		.sumsq   (sumsq),
		.ctl_out (sq_ctl),
		.vec_out (sq_vec),
		.root    (root)
	);

	prd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (sq_ctl),
		.vec_in (sq_vec),
		.root   (root),
		.done   (done),
		.dir_x  (dir_x),
		.dir_y  (dir_y),
		.dir_z  (dir_z)
	);

endmodule

/* rtl/core/prd_cam.sv */
// ----------------------------------------------------------------------------
// prd_cam
// Camera-space vector: offsets from the principal point, cross products with
// the focal lengths and block scaling to a 30-bit magnitude. Four stages.
// ----------------------------------------------------------------------------
module prd_cam (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [prd_pkg::COORD_BITS-1:0]    pixel_row,
	input  logic [prd_pkg::COORD_BITS-1:0]    pixel_col,
	input  logic [prd_pkg::FOCAL_W-1:0]       focal_x,
	input  logic [prd_pkg::FOCAL_W-1:0]       focal_y,
	input  logic [prd_pkg::FOCAL_W-1:0]       center_x,
	input  logic [prd_pkg::FOCAL_W-1:0]       center_y,
	output prd_pkg::prd_ctl_t                 ctl_out,
	output prd_pkg::prd_vec_t                 vec_out
);

	logic [prd_pkg::DIFF_W-1:0] dx, dy;
	prd_pkg::prd_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [1:0] neg_s1, neg_s2, neg_s3;
	logic [prd_pkg::FOCAL_W-1:0] dxm_s1, dym_s1;
	logic [2:0][prd_pkg::PROD_W-1:0] mag_s2, mag_s3;
	logic [prd_pkg::LZ_W-1:0] lz_s3;
	prd_pkg::prd_vec_t vec_s4;

	// Signed offsets of the pixel from the principal point.
	always_comb begin
		dx = prd_pkg::DIFF_W'({pixel_row, prd_pkg::FRAC_BITS'(0)})
			- prd_pkg::DIFF_W'(center_x);
		dy = prd_pkg::DIFF_W'({pixel_col, prd_pkg::FRAC_BITS'(0)})
			- prd_pkg::DIFF_W'(center_y);
	end

	// Valid bits of all four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1.valid <= in_valid;
			ctl_s1.zero  <= (focal_x == '0) || (focal_y == '0);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Data path: magnitudes, products, shared leading zeros, scaling.
	always_ff @(posedge clk) begin
		neg_s1 <= {dy[prd_pkg::DIFF_W-1], dx[prd_pkg::DIFF_W-1]};
		dxm_s1 <= dx[prd_pkg::DIFF_W-1] ? prd_pkg::FOCAL_W'(-dx) : prd_pkg::FOCAL_W'(dx);
		dym_s1 <= dy[prd_pkg::DIFF_W-1] ? prd_pkg::FOCAL_W'(-dy) : prd_pkg::FOCAL_W'(dy);

		neg_s2    <= neg_s1;
		mag_s2[0] <= prd_pkg::PROD_W'(dxm_s1) * prd_pkg::PROD_W'(focal_y);
		mag_s2[1] <= prd_pkg::PROD_W'(dym_s1) * prd_pkg::PROD_W'(focal_x);
		mag_s2[2] <= prd_pkg::PROD_W'(focal_x) * prd_pkg::PROD_W'(focal_y);

		neg_s3 <= neg_s2;
		mag_s3 <= mag_s2;
		lz_s3  <= prd_pkg::lzc64(mag_s2[0] | mag_s2[1] | mag_s2[2]);

		vec_s4.neg <= {1'b0, neg_s3};
		for (int i = 0; i < 3; i++) begin
			vec_s4.mag[i] <= prd_pkg::norm64(mag_s3[i], lz_s3);
		end
	end

	assign ctl_out = ctl_s4;
	assign vec_out = vec_s4;

endmodule

/* rtl/core/prd_rot.sv */
// ----------------------------------------------------------------------------
// prd_rot
// Rotation by the inverse pose matrix, block scaling of the result and the
// sum of squares for the norm. Seven stages.
// ----------------------------------------------------------------------------
module prd_rot (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prd_pkg::prd_ctl_t               ctl_in,
	input  prd_pkg::prd_vec_t               vec_in,
	input  prd_pkg::prd_mat_t               mat,
	output prd_pkg::prd_ctl_t               ctl_out,
	output prd_pkg::prd_vec_t               vec_out,
	output logic [prd_pkg::SQ_W-1:0]        sumsq
);

	logic signed [2:0][prd_pkg::VEC_W-1:0] v;
	prd_pkg::prd_ctl_t ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11;
	logic signed [2:0][2:0][prd_pkg::MP_W-1:0] p_s5;
	logic signed [2:0][prd_pkg::W_W-1:0] w_s6;
	logic [2:0] neg_s7, neg_s8, neg_s9, neg_s10, neg_s11;
	logic [2:0][prd_pkg::W_W-1:0] wm_s7, wm_s8;
	logic [2:0][63:0] wx, wx8;
	logic [prd_pkg::LZ_W-1:0] lz_s8;
	logic [2:0][prd_pkg::NORM_BITS-1:0] m_s9, m_s10, m_s11;
	logic [2:0][prd_pkg::SQ_W-1:0] sq_s10;
	logic [prd_pkg::SQ_W-1:0] sum_s11;

	// Signed camera vector and the scaled magnitudes left aligned in 64 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = vec_in.neg[i]
				? -$signed({1'b0, vec_in.mag[i]})
				: $signed({1'b0, vec_in.mag[i]});
			wx[i]  = 64'(wm_s7[i]) << (64 - prd_pkg::W_W);
			wx8[i] = 64'(wm_s8[i]) << (64 - prd_pkg::W_W);
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
		end else begin
			ctl_s5 <= ctl_in;
			ctl_s6 <= ctl_s5;
			ctl_s7.valid <= ctl_s6.valid;
			ctl_s7.zero  <= ctl_s6.zero || ((w_s6[0] == '0) && (w_s6[1] == '0)
				&& (w_s6[2] == '0));
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
		end
	end

	// Data path.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_s5[i][j] <= $signed(mat[i][j]) * $signed(v[j]);
			end
			w_s6[i] <= prd_pkg::W_W'($signed(p_s5[i][0]))
				+ prd_pkg::W_W'($signed(p_s5[i][1]))
				+ prd_pkg::W_W'($signed(p_s5[i][2]));
			neg_s7[i] <= w_s6[i][prd_pkg::W_W-1];
			wm_s7[i]  <= w_s6[i][prd_pkg::W_W-1] ? prd_pkg::W_W'(-w_s6[i])
				: prd_pkg::W_W'(w_s6[i]);
			m_s9[i]   <= prd_pkg::norm64(wx8[i], lz_s8);
			sq_s10[i] <= prd_pkg::SQ_W'(m_s9[i]) * prd_pkg::SQ_W'(m_s9[i]);
		end
		neg_s8  <= neg_s7;
		wm_s8   <= wm_s7;
		lz_s8   <= prd_pkg::lzc64(wx[0] | wx[1] | wx[2]);
		neg_s9  <= neg_s8;
		neg_s10 <= neg_s9;
		m_s10   <= m_s9;
		neg_s11 <= neg_s10;
		m_s11   <= m_s10;
		sum_s11 <= sq_s10[0] + sq_s10[1] + sq_s10[2];
	end

	assign ctl_out     = ctl_s11;
	assign vec_out.neg = neg_s11;
	assign vec_out.mag = m_s11;
	assign sumsq       = sum_s11;

endmodule

/* rtl/core/prd_isqrt.sv */
// ----------------------------------------------------------------------------
// prd_isqrt
// Pipelined integer square root, one result bit per stage, most significant
// bit first. The vector travels alongside.
// ----------------------------------------------------------------------------
module prd_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prd_pkg::prd_ctl_t               ctl_in,
	input  prd_pkg::prd_vec_t               vec_in,
	input  logic [prd_pkg::SQ_W-1:0]        sumsq,
	output prd_pkg::prd_ctl_t               ctl_out,
	output prd_pkg::prd_vec_t               vec_out,
	output logic [prd_pkg::RT_W-1:0]        root
);

	prd_pkg::prd_ctl_t ctl_s [prd_pkg::RT_W+1];
	prd_pkg::prd_vec_t vec_s [prd_pkg::RT_W+1];
	logic [prd_pkg::SQ_W-1:0] rem_s [prd_pkg::RT_W+1];
	logic [prd_pkg::RT_W-1:0] res_s [prd_pkg::RT_W+1];

	assign ctl_s[0] = ctl_in;
	assign vec_s[0] = vec_in;
	assign rem_s[0] = sumsq;
	assign res_s[0] = '0;

	for (genvar i = 0; i < prd_pkg::RT_W; i++) begin : g_stage
		localparam int K = prd_pkg::RT_W - 1 - i;
		logic [prd_pkg::SQ_W-1:0] trial;

		// Growth of the square when bit K of the root is set.
		assign trial = (prd_pkg::SQ_W'(res_s[i]) << (K + 1))
			+ (prd_pkg::SQ_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			vec_s[i+1] <= vec_s[i];
			if (rem_s[i] >= trial) begin
				rem_s[i+1] <= rem_s[i] - trial;
				res_s[i+1] <= res_s[i] | (prd_pkg::RT_W'(1) << K);
			end else begin
				rem_s[i+1] <= rem_s[i];
				res_s[i+1] <= res_s[i];
			end
		end
	end

	assign ctl_out = ctl_s[prd_pkg::RT_W];
	assign vec_out = vec_s[prd_pkg::RT_W];
	assign root    = res_s[prd_pkg::RT_W];

endmodule

/* rtl/core/prd_div.sv */
// ----------------------------------------------------------------------------
// prd_div
// Three parallel restoring dividers, one quotient bit per stage, followed by
// sign, saturation, zero forcing and the output register.
// ----------------------------------------------------------------------------
module prd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  prd_pkg::prd_ctl_t                   ctl_in,
	input  prd_pkg::prd_vec_t                   vec_in,
	input  logic [prd_pkg::RT_W-1:0]            root,
	output logic                                done,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_x,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_y,
	output logic signed [prd_pkg::DIR_BITS-1:0] dir_z
);

	prd_pkg::prd_ctl_t ctl_s [prd_pkg::DIR_BITS+1];
	logic [2:0] neg_s [prd_pkg::DIR_BITS+1];
	logic [prd_pkg::RT_W-1:0] den_s [prd_pkg::DIR_BITS+1];
	logic [2:0][prd_pkg::RM_W-1:0] rem_s [prd_pkg::DIR_BITS+1];
	logic [2:0][prd_pkg::DIR_BITS-1:0] quo_s [prd_pkg::DIR_BITS+1];
	logic [2:0][prd_pkg::DIR_BITS-1:0] res;
	logic done_q;
	logic [2:0][prd_pkg::DIR_BITS-1:0] dir_q;

	assign ctl_s[0] = ctl_in;
	assign neg_s[0] = vec_in.neg;
	assign den_s[0] = root;
	assign quo_s[0] = '0;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rem_s[0][l] = prd_pkg::RM_W'(vec_in.mag[l]);
		end
	end

	for (genvar i = 0; i < prd_pkg::DIR_BITS; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		// One fractional quotient bit per lane.
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			den_s[i+1] <= den_s[i];
			for (int l = 0; l < 3; l++) begin
				if (rem_s[i][l] >= prd_pkg::RM_W'(den_s[i])) begin
					rem_s[i+1][l] <= (rem_s[i][l] - prd_pkg::RM_W'(den_s[i])) << 1;
					quo_s[i+1][l] <= {quo_s[i][l][prd_pkg::DIR_BITS-2:0], 1'b1};
				end else begin
					rem_s[i+1][l] <= rem_s[i][l] << 1;
					quo_s[i+1][l] <= {quo_s[i][l][prd_pkg::DIR_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Apply sign, clamp positive results, force zero for degenerate requests.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (ctl_s[prd_pkg::DIR_BITS].zero) begin
				res[l] = '0;
			end else if (neg_s[prd_pkg::DIR_BITS][l]) begin
				res[l] = -quo_s[prd_pkg::DIR_BITS][l];
			end else if (quo_s[prd_pkg::DIR_BITS][l] > prd_pkg::MAX_POS) begin
				res[l] = prd_pkg::MAX_POS;
			end else begin
				res[l] = quo_s[prd_pkg::DIR_BITS][l];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[prd_pkg::DIR_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		dir_q <= res;
	end

	assign done  = done_q;
	assign dir_x = dir_q[0];
	assign dir_y = dir_q[1];
	assign dir_z = dir_q[2];

endmodule
